// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int unsigned COUNT_W = 5;
	localparam int unsigned MIN_W   = 32;
	localparam int unsigned STAT_W  = 2;

	typedef enum logic [STAT_W-1:0] {
		SPQ_OK        = 2'd0,
		SPQ_REM_EMPTY = 2'd1,
		SPQ_INS_FULL  = 2'd2
	} spq_status_t;

	typedef enum logic {
		SPQ_FUNC_INSERT = 1'b0,
		SPQ_FUNC_REMOVE = 1'b1
	} spq_func_t;

	typedef enum logic {
		SPQ_IDLE,
		SPQ_EXEC
	} spq_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

	typedef struct packed {
		logic out_stall;
	} spq_stat_t;

endpackage

// File: hw/rtl/spq_if.sv
// Request and result channel interfaces of the sorted priority queue.
interface spq_in_if #(
	parameter int unsigned KEY_BITS = 32
);
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [KEY_BITS-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink (input valid, input func, input key, output ready);
endinterface

interface spq_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] min_key;
	logic [4:0]         count;
	logic               is_empty;
	logic [1:0]         status;

	modport source (output valid, output min_key, output count, output is_empty,
		output status, input ready);
	modport sink (input valid, input min_key, input count, input is_empty,
		input status, output ready);
endinterface

// File: hw/rtl/spq_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	spq_state_t state_q;
	spq_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SPQ_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SPQ_IDLE: begin
				if (in_valid) state_nxt = SPQ_EXEC;
			end
			SPQ_EXEC: begin
				if (!stat.out_stall) state_nxt = SPQ_IDLE;
			end
			default: state_nxt = SPQ_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			SPQ_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			SPQ_EXEC: begin
				cmd.exec = !stat.out_stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: hw/rtl/spq_dpath.sv
// Datapath: the row of compare-and-shift key cells, entry count and result register.
module spq_dpath
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_cmd_t                   cmd,
	output spq_stat_t                  stat,
	input  logic                       in_func,
	input  logic signed [KEY_BITS-1:0] in_key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [MIN_W-1:0]    out_min_key,
	output logic [COUNT_W-1:0]         out_count,
	output logic                       out_is_empty,
	output logic [STAT_W-1:0]          out_status
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic                       func_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic signed [KEY_BITS-1:0] keys_q [CAPACITY];
	logic signed [KEY_BITS-1:0] keys_upd [CAPACITY];
	logic signed [KEY_BITS-1:0] head_new;
	logic [CAPACITY-1:0]        le;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_new;
	logic                       full;
	logic                       empty;
	logic                       apply;
	spq_status_t                status_new;
	logic signed [63:0]         min_ext;
	logic [CW+COUNT_W-1:0]      count_ext;

	logic                       out_valid_q;
	logic signed [MIN_W-1:0]    min_key_q;
	logic [COUNT_W-1:0]         count_out_q;
	logic                       is_empty_q;
	logic [STAT_W-1:0]          status_q;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign le[i] = (CW'(i) < count_q) && (keys_q[i] <= key_q);

		if (i == 0) begin : g_head
			assign keys_upd[i] = (func_q == SPQ_FUNC_REMOVE)
				? ((CAPACITY > 1) ? keys_q[(CAPACITY > 1) ? 1 : 0] : keys_q[i])
				: (le[i] ? keys_q[i] : key_q);
		end else if (i == CAPACITY - 1) begin : g_tail
			assign keys_upd[i] = (func_q == SPQ_FUNC_REMOVE) ? keys_q[i]
				: (le[i] ? keys_q[i] : (le[i-1] ? key_q : keys_q[i-1]));
		end else begin : g_mid
			assign keys_upd[i] = (func_q == SPQ_FUNC_REMOVE) ? keys_q[i+1]
				: (le[i] ? keys_q[i] : (le[i-1] ? key_q : keys_q[i-1]));
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && apply) begin
				keys_q[i] <= keys_upd[i];
			end
		end
	end

	assign head_new = apply ? keys_upd[0] : keys_q[0];

	always_comb begin
		apply      = 1'b0;
		count_new  = count_q;
		status_new = SPQ_OK;
		if (func_q == SPQ_FUNC_REMOVE) begin
			if (empty) begin
				status_new = SPQ_REM_EMPTY;
			end else begin
				apply     = 1'b1;
				count_new = count_q - 1'b1;
			end
		end else begin
			if (full) begin
				status_new = SPQ_INS_FULL;
			end else begin
				apply     = 1'b1;
				count_new = count_q + 1'b1;
			end
		end
	end

	assign min_ext   = (count_new != '0) ? 64'(head_new) : '0;
	assign count_ext = (CW + COUNT_W)'(count_new);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			key_q  <= in_key;
		end
		if (cmd.exec) begin
			min_key_q   <= min_ext[MIN_W-1:0];
			count_out_q <= count_ext[COUNT_W-1:0];
			is_empty_q  <= (count_new == '0);
			status_q    <= status_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_stall = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign out_min_key    = min_key_q;
	assign out_count      = count_out_q;
	assign out_is_empty   = is_empty_q;
	assign out_status     = status_q;

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue top level: a min-queue of signed keys kept in ascending order.
// Each request is first captured in the idle state; then, in the execute state, every
// key cell compares itself with the new key and holds, takes the new key or shifts by
// one place, all at once. The result register lets the next request be captured while
// a result still waits; if a result is held back, the update of the following request
// waits for it. Equal keys leave in arrival order, an insert into a full queue and a
// removal from an empty one leave the queue unchanged.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	spq_in_if.sink    in,
	spq_out_if.source out
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spq_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_func      (in.func),
		.in_key       (in.key),
		.out_valid    (out.valid),
		.out_ready    (out.ready),
		.out_min_key  (out.min_key),
		.out_count    (out.count),
		.out_is_empty (out.is_empty),
		.out_status   (out.status)
	);

endmodule

// File: hw/rtl/spq_checker.sv
// Port-level checks of the sorted priority queue and their binding to the top level.
module spq_checker
	import spq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_min_key,
	input logic [4:0]         out_count,
	input logic               out_is_empty,
	input logic [1:0]         out_status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_min_key)
			&& $stable(out_count) && $stable(out_status))
		else $error("result changed while stalled");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_empty |-> out_min_key == 32'sd0 && out_count == 5'd0)
		else $error("empty queue reports a key or a count");

	a_rem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == SPQ_REM_EMPTY |-> out_is_empty)
		else $error("removal flagged as empty on a queue that holds keys");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == SPQ_OK || out_status == SPQ_REM_EMPTY
			|| out_status == SPQ_INS_FULL)
		else $error("undefined status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out.valid),
	.out_ready    (out.ready),
	.out_min_key  (out.min_key),
	.out_count    (out.count),
	.out_is_empty (out.is_empty),
	.out_status   (out.status)
);
